/* src/pks_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_pkg
// Shared types, constants and helpers of the PKCS#1 v1.5 padding stripper.
// ----------------------------------------------------------------------------
package pks_pkg;

  localparam int MAX_BLOCK_BYTES = 512;
  localparam int CNT_W           = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int MIN_PAD_BYTES   = 8;
  localparam int MIN_LEN_TYPE1   = 10;
  localparam int MIN_LEN_TYPE2   = 3;
  localparam int PLEN_MAX        = 1023;

  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int APB_ADDR_W      = 4;
  localparam int APB_DATA_W      = 32;

  localparam logic [7:0] BT_TYPE1 = 8'h01;
  localparam logic [7:0] BT_TYPE2 = 8'h02;
  localparam logic [7:0] PAD_FF   = 8'hFF;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_TYPE,
    PH_PAD,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_PAD,
    ST_BAD_LEN,
    ST_OVER_CAP
  } status_e;

  typedef enum logic [1:0] {
    REG_BLOCK_TYPE,
    REG_CHECK_ONLY,
    REG_CAPACITY,
    REG_NONE
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] block_type;
    logic       check_only;
    logic [9:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       block_done;
    status_e    status;
    logic [9:0] payload_length;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (32'(v) < MAX_BLOCK_BYTES) ? v + 1'b1 : v;
  endfunction

endpackage

/* src/pks_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_front
// Byte parser: tracks the padding state and builds one result record per
// payload byte kept (none if check_only or over capacity) or block end.
// ----------------------------------------------------------------------------
module pks_front
  import pks_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output res_t       res_o
);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] blk_cnt_q, blk_cnt_d;
  logic [CNT_W-1:0] pad_cnt_q, pad_cnt_d;
  logic [CNT_W-1:0] pay_cnt_q, pay_cnt_d;
  logic             err_q, err_d;

  logic       accept;
  logic       type2;
  logic [7:0] expect_type;
  logic       emit;
  status_e    status;
  logic [9:0] plen;
  int         min_len;

  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign type2       = (cfg_i.block_type == 2'd2);
  assign expect_type = type2 ? BT_TYPE2 : BT_TYPE1;
  assign min_len     = type2 ? MIN_LEN_TYPE2 : MIN_LEN_TYPE1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      blk_cnt_q <= '0;
      pad_cnt_q <= '0;
      pay_cnt_q <= '0;
      err_q     <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      blk_cnt_q <= blk_cnt_d;
      pad_cnt_q <= pad_cnt_d;
      pay_cnt_q <= pay_cnt_d;
      err_q     <= err_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    blk_cnt_d = sat_inc(blk_cnt_q);
    pad_cnt_d = pad_cnt_q;
    pay_cnt_d = pay_cnt_q;
    err_d     = err_q;
    emit      = 1'b0;
    status    = ST_OK;
    plen      = '0;

    if (!err_q) begin
      case (phase_q)
        PH_FIRST, PH_TYPE: begin
          // leading zero is only skipped once, in the first position
          if (phase_q == PH_FIRST && data_byte_i == 8'h00) begin
            phase_d = PH_TYPE;
          end else if (data_byte_i == expect_type) begin
            phase_d   = PH_PAD;
            pad_cnt_d = '0;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_PAD: begin
          if (data_byte_i == 8'h00) begin
            if (32'(pad_cnt_q) >= MIN_PAD_BYTES) begin
              phase_d = PH_DATA;
            end else begin
              err_d = 1'b1;
            end
          end else if (type2 || data_byte_i == PAD_FF) begin
            pad_cnt_d = sat_inc(pad_cnt_q);
          end else begin
            err_d = 1'b1;
          end
        end
        PH_DATA: begin
          emit      = !cfg_i.check_only && (32'(pay_cnt_q) < 32'(cfg_i.capacity));
          pay_cnt_d = sat_inc(pay_cnt_q);
        end
        default: ;
      endcase
    end

    if (last_byte_i) begin
      if (32'(blk_cnt_d) < min_len) begin
        status = ST_BAD_LEN;
      end else if (err_d || phase_d != PH_DATA) begin
        status = ST_BAD_PAD;
      end else if (!cfg_i.check_only && (32'(pay_cnt_d) > 32'(cfg_i.capacity))) begin
        status = ST_OVER_CAP;
      end
      if (status == ST_OK) begin
        plen = (32'(pay_cnt_d) > PLEN_MAX) ? 10'(PLEN_MAX) : 10'(pay_cnt_d);
      end
      phase_d   = PH_FIRST;
      blk_cnt_d = '0;
      pad_cnt_d = '0;
      pay_cnt_d = '0;
      err_d     = 1'b0;
    end
  end

  assign push_o                = accept && (emit || last_byte_i);
  assign res_o.payload_byte    = emit ? data_byte_i : 8'h00;
  assign res_o.payload_valid   = emit;
  assign res_o.block_done      = last_byte_i;
  assign res_o.status          = status;
  assign res_o.payload_length  = plen;

endmodule

/* src/pks_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_fifo
// Small result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module pks_fifo
  import pks_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output res_t rdata_o
);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* src/pks_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pks_back
// Output register: takes result records from the queue and holds each one
// on the output channel until it is transferred.
// ----------------------------------------------------------------------------
module pks_back
  import pks_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  res_t q_data_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign q_pop_o     = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= q_data_i;
    end
  end

endmodule

/* src/pkcs1_v15_padding_strip_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs1_v15_padding_strip_top
// PKCS#1 v1.5 padding check and strip for a byte stream of decrypted blocks.
//
// Input channel: one block byte per transfer (data_byte_i, last_byte_i).
// Output channel: one record per payload byte kept (none if check_only or
// over capacity) and one on the block's last byte (payload_valid_o and
// block_done_o may both be set); bytes that open or pad the block give no
// record. status_o and payload_length_o are meaningful with block_done_o.
// Path: queue write as the byte transfers, then the output register.
// Throughput: one byte per cycle while the queue has space, set by the
// byte parser; a four-entry queue plus the output register decouple it
// from the receiver. When the receiver stalls, input keeps flowing until
// the queue fills, then in_ready_o drops. Bytes that give no record never
// wait for space in a way that loses data; they simply wait for in_ready_o
// as well. Reset: parser returns to "first byte expected", the queue empties
// and the registers take block_type 1, check_only 0, payload_capacity 512.
// Configuration (APB, pready always high) is to be written by the user only
// while the block idles, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module pkcs1_v15_padding_strip_top
  import pks_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            payload_byte_o,
  output logic                  payload_valid_o,
  output logic                  block_done_o,
  output logic [1:0]            status_o,
  output logic [9:0]            payload_length_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  logic full, push, q_valid, q_pop;
  res_t front_res, q_res, out_res;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_type <= 2'd1;
      cfg_q.check_only <= 1'b0;
      cfg_q.capacity   <= 10'd512;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BLOCK_TYPE: cfg_q.block_type <= pwdata[1:0];
        REG_CHECK_ONLY: cfg_q.check_only <= pwdata[0];
        REG_CAPACITY:   cfg_q.capacity   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLOCK_TYPE: prdata = APB_DATA_W'(cfg_q.block_type);
      REG_CHECK_ONLY: prdata = APB_DATA_W'(cfg_q.check_only);
      REG_CAPACITY:   prdata = APB_DATA_W'(cfg_q.capacity);
      default:        prdata = '0;
    endcase
  end

  pks_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .full_i      (full),
    .push_o      (push),
    .res_o       (front_res)
  );

  pks_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_res),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_res)
  );

  pks_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_res),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign payload_byte_o   = out_res.payload_byte;
  assign payload_valid_o  = out_res.payload_valid;
  assign block_done_o     = out_res.block_done;
  assign status_o         = out_res.status;
  assign payload_length_o = out_res.payload_length;

endmodule
